### sv/dirt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the device identifier registry table.
package dirt_pkg;

	localparam int CAPACITY = 16;

	localparam int ID_W    = 16;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 4;
	localparam int ENTRY_W = 5;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_EXISTS = 2'd1;
	localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic [ID_W-1:0] req_id;
		logic            add_en;
		logic            remove_en;
	} cell_cmd_t;

endpackage

### sv/dirt_cell.sv
`timescale 1ns / 1ps
// One slot of the identifier chain: stores an identifier, compares it and shifts on removal.
module dirt_cell (
	input  logic                        clk,
	input  dirt_pkg::cell_cmd_t         cmd,
	input  logic                        live,
	input  logic                        tail,
	input  logic [dirt_pkg::ID_W-1:0]   next_id,
	input  logic                        seen_in,
	output logic [dirt_pkg::ID_W-1:0]   id,
	output logic                        match,
	output logic                        seen_out
);

	logic [dirt_pkg::ID_W-1:0] id_q;

	assign id       = id_q;
	assign match    = live && (id_q == cmd.req_id);
	// The removal mark ripples upward: this cell and every cell above the match take
	// their upper neighbor's identifier.
	assign seen_out = seen_in | match;

	always_ff @(posedge clk) begin
		if (cmd.add_en && tail) begin
			id_q <= cmd.req_id;
		end else if (cmd.remove_en && seen_out) begin
			id_q <= next_id;
		end
	end

endmodule

### sv/device_id_registry_table_top.sv
`timescale 1ns / 1ps
// Top level of the device identifier registry table.

// The block keeps an ordered, compact list of up to 16 distinct 16-bit device
// identifiers in a row of identical cells. Every request transaction carries an
// operation (add, remove or look up) and an identifier, and produces exactly one
// result transaction with a status, a found flag, a position and the number of
// live entries after the request. All cells compare the identifier at once; a
// removal closes the gap by having every cell from the matching slot upward take
// its upper neighbor's identifier in the same clock edge. The result of a request
// appears in the output register in the cycle after the request is accepted,
// so the block sustains one transaction per clock as long as results are taken.
// The cycle time is set by the parallel 16-bit compares followed by the ripple of
// the removal mark through the chain of cells. The output register lets a new
// request be accepted while the previous result is being taken in the same cycle.
// Identifiers in slots above the live count are never looked at, so the slots
// need no clearing after reset; only the live count and the result valid flag
// are reset.
module device_id_registry_table_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [dirt_pkg::OP_W-1:0]      operation,
	input  logic [dirt_pkg::ID_W-1:0]      dev_ident,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [dirt_pkg::STAT_W-1:0]    status,
	output logic                           found,
	output logic [dirt_pkg::POS_W-1:0]     position,
	output logic [dirt_pkg::ENTRY_W-1:0]   entry_count
);

	localparam int CAP = dirt_pkg::CAPACITY;

	// Number of live entries; slots below this count hold valid identifiers.
	logic [dirt_pkg::CNT_W-1:0] count_q;
	logic [dirt_pkg::CNT_W-1:0] count_nxt;

	// Result register and its valid flag.
	logic                         out_valid_q;
	logic [dirt_pkg::STAT_W-1:0]  status_q;
	logic                         found_q;
	logic [dirt_pkg::POS_W-1:0]   position_q;
	logic [dirt_pkg::ENTRY_W-1:0] entry_count_q;

	logic accept;

	// Chain wiring.
	dirt_pkg::cell_cmd_t       cmd;
	logic [dirt_pkg::ID_W-1:0] cell_id [CAP];
	logic [CAP-1:0]            match_vec;
	logic [CAP:0]              seen;
	logic [CAP-1:0]            live_vec;
	logic [CAP-1:0]            tail_vec;

	logic                       any_hit;
	logic                       full;
	logic [dirt_pkg::IDX_W-1:0] hit_idx;

	logic [dirt_pkg::STAT_W-1:0] status_d;
	logic                        found_d;
	logic [dirt_pkg::POS_W-1:0]  position_d;
	logic                        add_ok;
	logic                        remove_ok;

	// A new request is taken whenever the result register is empty or being drained.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign seen[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < CAP; gi++) begin : g_cell
			logic [dirt_pkg::ID_W-1:0] next_id;

			assign live_vec[gi] = dirt_pkg::CNT_W'(gi) < count_q;
			assign tail_vec[gi] = count_q == dirt_pkg::CNT_W'(gi);

			if (gi < CAP - 1) begin : g_mid
				assign next_id = cell_id[gi+1];
			end else begin : g_last
				// The top slot keeps its value; it falls out of the live range anyway.
				assign next_id = cell_id[gi];
			end

			dirt_cell u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.live     (live_vec[gi]),
				.tail     (tail_vec[gi]),
				.next_id  (next_id),
				.seen_in  (seen[gi]),
				.id       (cell_id[gi]),
				.match    (match_vec[gi]),
				.seen_out (seen[gi+1])
			);
		end
	endgenerate

	assign any_hit = |match_vec;
	assign full    = count_q == dirt_pkg::CNT_W'(CAP);

	// Live identifiers are distinct, so at most one cell matches and an OR encoder suffices.
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < CAP; i++) begin
			if (match_vec[i]) begin
				hit_idx = hit_idx | dirt_pkg::IDX_W'(i);
			end
		end
	end

	// Request decoder.
	always_comb begin
		status_d   = dirt_pkg::ST_OK;
		found_d    = 1'b0;
		position_d = '0;
		add_ok     = 1'b0;
		remove_ok  = 1'b0;
		count_nxt  = count_q;
		unique case (operation)
			dirt_pkg::OP_ADD: begin
				if (any_hit) begin
					status_d   = dirt_pkg::ST_EXISTS;
					position_d = dirt_pkg::POS_W'(hit_idx);
				end else if (full) begin
					status_d = dirt_pkg::ST_FULL;
				end else begin
					add_ok     = 1'b1;
					position_d = dirt_pkg::POS_W'(count_q[dirt_pkg::IDX_W-1:0]);
					count_nxt  = count_q + dirt_pkg::CNT_W'(1);
				end
			end
			dirt_pkg::OP_REMOVE: begin
				if (!any_hit) begin
					status_d = dirt_pkg::ST_ABSENT;
				end else begin
					remove_ok  = 1'b1;
					position_d = dirt_pkg::POS_W'(hit_idx);
					count_nxt  = count_q - dirt_pkg::CNT_W'(1);
				end
			end
			dirt_pkg::OP_LOOKUP: begin
				if (!any_hit) begin
					status_d = dirt_pkg::ST_ABSENT;
				end else begin
					found_d    = 1'b1;
					position_d = dirt_pkg::POS_W'(hit_idx);
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd.req_id    = dev_ident;
	assign cmd.add_en    = accept && add_ok;
	assign cmd.remove_en = accept && remove_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_d;
			found_q       <= found_d;
			position_q    <= position_d;
			entry_count_q <= dirt_pkg::ENTRY_W'(count_nxt);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found       = found_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;

endmodule

### sv/dirt_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the registry table and their binding to the top level.
module dirt_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [dirt_pkg::STAT_W-1:0]    status,
	input  logic                           found,
	input  logic [dirt_pkg::POS_W-1:0]     position,
	input  logic [dirt_pkg::ENTRY_W-1:0]   entry_count
);

	// A stalled result holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found)
			&& $stable(position) && $stable(entry_count))
		else $error("stalled result changed");

	// A found flag only comes with a successful status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == dirt_pkg::ST_OK)
		else $error("found set with a failing status");

	// A full report means the table really holds its capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dirt_pkg::ST_FULL
			|-> entry_count == dirt_pkg::ENTRY_W'(dirt_pkg::CAPACITY))
		else $error("table full reported below capacity");

	// Misses and full reports carry a zero position.
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == dirt_pkg::ST_ABSENT || status == dirt_pkg::ST_FULL)
			|-> position == '0)
		else $error("nonzero position on a miss");

	// The live count never exceeds the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= dirt_pkg::ENTRY_W'(dirt_pkg::CAPACITY))
		else $error("entry count above capacity");

endmodule

bind device_id_registry_table_top dirt_checker u_dirt_checker (.*);

### verif/tb_device_id_registry_table_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the device identifier registry table.

import dirt_pkg::*;

// One expected or observed result transaction.
typedef struct packed {
	logic [STAT_W-1:0]  status;
	logic               found;
	logic [POS_W-1:0]   position;
	logic [ENTRY_W-1:0] entry_count;
} registry_result_t;

// Scoreboard with its own copy of the table. It predicts the result of each
// accepted request and checks the results in order of arrival.
class registry_scoreboard;
	logic [ID_W-1:0]  slot_ids [CAPACITY];
	int               live;
	registry_result_t awaited_results [$];
	int               failures;

	function new();
		live     = 0;
		failures = 0;
	endfunction

	function int pending();
		return awaited_results.size();
	endfunction

	// Updates the table for one accepted request and queues its result.
	function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
		registry_result_t r;
		int hit;
		hit = -1;
		r   = '0;
		for (int i = 0; i < live; i++) begin
			if (hit < 0 && slot_ids[i] == id)
				hit = i;
		end
		case (op)
			OP_ADD: begin
				if (hit >= 0) begin
					r.status   = ST_EXISTS;
					r.position = POS_W'(hit);
				end else if (live >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					slot_ids[live] = id;
					r.position     = POS_W'(live);
					live++;
				end
			end
			OP_REMOVE: begin
				if (hit < 0) begin
					r.status = ST_ABSENT;
				end else begin
					r.position = POS_W'(hit);
					for (int i = hit; i + 1 < live; i++)
						slot_ids[i] = slot_ids[i + 1];
					live--;
				end
			end
			OP_LOOKUP: begin
				if (hit < 0) begin
					r.status = ST_ABSENT;
				end else begin
					r.found    = 1'b1;
					r.position = POS_W'(hit);
				end
			end
			default: begin
			end
		endcase
		r.entry_count = ENTRY_W'(live);
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	// Compares one accepted result with the oldest prediction.
	function void check_result(registry_result_t got);
		registry_result_t want;
		if (awaited_results.size() == 0) begin
			$error("result arrived with no request outstanding");
			failures++;
			return;
		end
		want = awaited_results.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, got.status);
			failures++;
		end
		if (got.found !== want.found) begin
			$error("found: expected %0d, actual %0d", want.found, got.found);
			failures++;
		end
		if (got.position !== want.position) begin
			$error("position: expected %0d, actual %0d", want.position, got.position);
			failures++;
		end
		if (got.entry_count !== want.entry_count) begin
			$error("entry_count: expected %0d, actual %0d",
				want.entry_count, got.entry_count);
			failures++;
		end
	endfunction
endclass

module tb_device_id_registry_table_top;

	// The fourth operation code has no meaning in the block; it must leave the
	// table untouched and still produce a plain ok result.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int POOL_SIZE = 24;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     operation;
	logic [ID_W-1:0]     dev_ident;
	logic                out_valid;
	logic                out_ready;
	logic [STAT_W-1:0]   status;
	logic                found;
	logic [POS_W-1:0]    position;
	logic [ENTRY_W-1:0]  entry_count;

	// While steady is set neither the request side nor the result side idles,
	// which gives a long stretch at the full rate of one transaction per clock.
	logic                steady;

	// Identifiers that random requests mostly draw from. The pool is larger than
	// the table, so the table fills up, and it holds the identifiers left over
	// from the directed part, so every entry can be removed again later.
	logic [ID_W-1:0]     id_pool [POOL_SIZE];

	registry_scoreboard  sb = new();

	device_id_registry_table_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.dev_ident   (dev_ident),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found       (found),
		.position    (position),
		.entry_count (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result side: ready drops in roughly 27 percent of the cycles, except while
	// the steady stretch runs.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= steady || ($urandom_range(99) >= 27);
		end
	end

	// All inputs change only at rising edges, so at the falling edge both
	// handshakes are settled. A transaction seen there completes at the next
	// rising edge. The result is checked before the new request is noted, which
	// keeps the queue in acceptance order.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result({status, found, position, entry_count});
			if (in_valid && in_ready)
				sb.note_request(operation, dev_ident);
		end
	end

	// Presents one request transaction and returns at the rising edge that
	// accepts it. It must be called right after a rising edge. Outside the
	// steady stretch, valid first stays low for a random number of cycles.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
		bit taken;
		while (!steady && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		dev_ident <= id;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end
	endtask

	// Random requests with the given percentages for add, remove and look up;
	// what is left goes to the unused code. Most identifiers come from the pool
	// so that adds collide and removes hit; the rest are fully random so that
	// every identifier bit toggles.
	task automatic run_random(input int count, input int add_pct, input int remove_pct,
		input int lookup_pct);
		int              pick;
		logic [OP_W-1:0] op;
		logic [ID_W-1:0] id;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < add_pct)
				op = OP_ADD;
			else if (pick < add_pct + remove_pct)
				op = OP_REMOVE;
			else if (pick < add_pct + remove_pct + lookup_pct)
				op = OP_LOOKUP;
			else
				op = OP_UNUSED;
			if ($urandom_range(99) < 85)
				id = id_pool[$urandom_range(POOL_SIZE - 1)];
			else
				id = ID_W'($urandom);
			send_request(op, id);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = OP_ADD;
		dev_ident = '0;
		steady    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. An empty table: a lookup and a remove both miss.
		send_request(OP_LOOKUP, 16'h0000);
		send_request(OP_REMOVE, 16'hFFFF);
		// The extreme identifiers go in, then a duplicate add is refused and
		// reports where the existing entry sits.
		send_request(OP_ADD, 16'h0000);
		send_request(OP_ADD, 16'hFFFF);
		send_request(OP_ADD, 16'h0000);
		// The unused code changes nothing.
		send_request(OP_UNUSED, 16'h5A5A);
		// Removing the first entry shifts the other one down to slot zero.
		send_request(OP_REMOVE, 16'h0000);
		send_request(OP_LOOKUP, 16'hFFFF);
		// Fill the table with one-hot identifiers.
		for (int k = 0; k < CAPACITY - 1; k++)
			send_request(OP_ADD, ID_W'(1) << k);
		// An add to a full table is refused, the top slot is found, a removal
		// from the middle closes the gap, and the last entry is removed.
		send_request(OP_ADD, 16'h8000);
		send_request(OP_LOOKUP, 16'h4000);
		send_request(OP_REMOVE, 16'h0100);
		send_request(OP_REMOVE, 16'h4000);

		id_pool[0] = 16'hFFFF;
		for (int k = 0; k < CAPACITY - 1; k++)
			id_pool[k + 1] = ID_W'(1) << k;
		for (int k = CAPACITY; k < POOL_SIZE; k++)
			id_pool[k] = ID_W'($urandom);

		// Random part in phases: add-heavy to keep the table full, a steady
		// stretch with no idling, remove-heavy to drain the table to empty, and
		// a balanced mix to finish.
		run_random(150, 50, 20, 25);
		steady <= 1'b1;
		run_random(100, 35, 35, 25);
		steady <= 1'b0;
		run_random(120, 20, 55, 20);
		run_random(80, 35, 35, 25);

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// The extra wait after that catches any stray result after the last one.
		repeat (8) @(posedge clk);
		if (sb.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// This bound is far above the length of a correct run.
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
